### rtl/rca_pkg.sv
// Package for the reorientation correlation accumulator.
// Holds transaction structs, codes, state encoding and fixed widths.
// No dependencies.
`timescale 1ns / 1ps
package rca_pkg;

  // Default sizing of the top level
  localparam int SPECIES_MAX_DEF = 4;
  localparam int LAG_BINS_DEF    = 1024;
  localparam int FRAC_BITS_DEF   = 15;

  // Fixed widths of the accumulators
  localparam int FRAME_W = 40;
  localparam int SUM_W   = 48;
  localparam int CNT_W   = 24;
  localparam int WORD_W  = 2 * SUM_W + CNT_W;
  localparam int DIV_N_W = SUM_W + 1;
  localparam int DIV_D_W = CNT_W;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Configuration register indexes
  localparam logic REG_TIME_STEP = 1'b0;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_CLOSE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } rca_action_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ROUND,
    ST_SQUARE,
    ST_ACCUM,
    ST_STEP_GO,
    ST_STEP_RUN,
    ST_FETCH,
    ST_CHECK,
    ST_DIV1_GO,
    ST_DIV1_RUN,
    ST_DIV2_GO,
    ST_DIV2_RUN,
    ST_WRITE,
    ST_OUT
  } rca_state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [1:0]         species;
    logic [23:0]        elapsed_time;
    logic [9:0]         bin_index;
    logic signed [15:0] orient_x;
    logic signed [15:0] orient_y;
    logic signed [15:0] orient_z;
    logic signed [15:0] ref_x;
    logic signed [15:0] ref_y;
    logic signed [15:0] ref_z;
  } rca_item_t;

  typedef struct packed {
    logic [25:0]        lag_time;
    logic [23:0]        sample_count;
    logic signed [15:0] c1_average;
    logic signed [15:0] c2_average;
    logic               has_data;
    logic               dropped;
  } rca_result_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } rca_div_stat_t;

endpackage

### rtl/rca_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module rca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write through the port, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/rca_div.sv
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Uses rca_pkg for the status struct.
`timescale 1ns / 1ps
module rca_div #(
  parameter int N_W = rca_pkg::DIV_N_W,
  parameter int D_W = rca_pkg::DIV_D_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [N_W-1:0]         num,
  input  logic [D_W-1:0]         den,
  output rca_pkg::rca_div_stat_t stat,
  output logic [N_W-1:0]         quo
);

  localparam int C_W = $clog2(N_W + 1);

  logic [D_W-1:0] rem;
  logic [D_W-1:0] den_r;
  logic [C_W-1:0] cnt;
  logic [D_W:0]   trial;
  logic           fits;

  // Shift in the next numerator bit and test against the divisor
  always_comb begin
    trial = {rem, quo[N_W-1]};
    fits  = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= C_W'(N_W);
      end else if (stat.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == C_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // Datapath: numerator and quotient share the shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      den_r <= den;
      quo   <= num;
    end else if (stat.busy) begin
      rem <= fits ? D_W'(trial - {1'b0, den_r}) : D_W'(trial);
      quo <= {quo[N_W-2:0], fits};
    end
  end

endmodule

### rtl/reorientation_correlation_accumulator_core.sv
// Top level: sequencer, shared multiplier and divider, lag-bin memory.
// Depends on rca_pkg, rca_div and rca_ram.
//
//   channel  | valid         | stall         | payload
//   ---------+---------------+---------------+-----------------------
//   item     | item_valid    | item_stall    | item   (rca_item_t)
//   result   | result_valid  | result_stall  | result (rca_result_t)
//   config   | psel/penable  | pready (high) | paddr, pwdata, prdata
//
// Add sample: accept, three passes of the multiplier, round, square, sum.
// Close: accept and the bin index division; a close into a bin then adds fetch,
// check, two divisions and write, a full bin only fetch and check.
// Read: fetch, check, two divisions, output; an empty bin skips the divisions.
// The output waits under result_stall. Each division is a start state, then
// the serial divider over a 49-bit quotient. After reset a clearing pass zeroes
// all SPECIES_MAX*LAG_BINS bin words; items stall, configuration writes are taken.
// A pending result may wait under result_stall while the next item is taken.
`timescale 1ns / 1ps
module reorientation_correlation_accumulator_core #(
  parameter int SPECIES_MAX = rca_pkg::SPECIES_MAX_DEF,
  parameter int LAG_BINS    = rca_pkg::LAG_BINS_DEF,
  parameter int FRAC_BITS   = rca_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  rca_pkg::rca_item_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output rca_pkg::rca_result_t result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int DEPTH  = SPECIES_MAX * LAG_BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int X_W    = FRAC_BITS + 2;
  localparam int U_W    = 2 * X_W + 2;
  localparam int SH     = 30 - FRAC_BITS;
  localparam int HALF_SH = (SH > 0) ? SH - 1 : 0;
  localparam int FW = rca_pkg::FRAME_W;
  localparam int SW = rca_pkg::SUM_W;
  localparam int CW = rca_pkg::CNT_W;
  localparam int NW = rca_pkg::DIV_N_W;

  localparam logic signed [33:0] ONE30  = 34'sd1 <<< 30;
  localparam logic signed [33:0] HALF_D = (SH > 0) ? (34'sd1 <<< HALF_SH) : 34'sd0;
  localparam logic [U_W:0]       HALF_F = (U_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW+1:0] BIN_MAX = (SW + 2)'((65'sd1 <<< (SW - 1)) - 1);
  localparam logic signed [SW+1:0] BIN_MIN = -(SW + 2)'(65'sd1 <<< (SW - 1));

  rca_pkg::rca_state_t state, state_next;
  rca_pkg::rca_item_t  cur;

  logic [15:0]             time_step;
  logic [15:0]             step_eff;
  logic signed [33:0]      dot;
  logic signed [33:0]      d_sat;
  logic [1:0]              mul_idx;
  logic signed [15:0]      mul_a, mul_b;
  logic signed [31:0]      prod;
  logic signed [X_W-1:0]   x;
  logic signed [2*X_W-1:0] sq;
  logic [U_W-1:0]          u;
  logic signed [U_W:0]     p2_full;
  logic signed [X_W-1:0]   p2;
  logic signed [FW:0]      s1, s2;
  logic signed [FW-1:0]    fc1, fc2;
  logic [CW-1:0]           mol;
  logic                    dropped;
  logic [ADDR_W-1:0]       addr_reg, clr_addr, ram_addr;
  logic                    rd_ok;
  logic [NW-1:0]           q1, q2;
  logic                    ram_we;
  logic [rca_pkg::WORD_W-1:0] ram_wdata, ram_rdata;
  logic signed [SW-1:0]    bin_c1, bin_c2;
  logic [CW-1:0]           bin_cnt, cnt_eff;
  logic                    div_start;
  logic [NW-1:0]           div_num;
  logic [CW-1:0]           div_den;
  logic [NW-1:0]           div_quo;
  rca_pkg::rca_div_stat_t  div_stat;
  logic                    sp_ok, close_ok, frame_clear, cfg_wr;
  logic [31:0]             idx_close, idx_read;
  logic [FW-1:0]           mag_f1, mag_f2;
  logic [SW-1:0]           mag_b1, mag_b2;
  logic signed [SW+1:0]    avg1, avg2, bs1, bs2;
  logic signed [SW-1:0]    new_c1, new_c2;
  logic signed [15:0]      rd_c1, rd_c2;
  rca_pkg::rca_result_t    res_next;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == rca_pkg::REG_TIME_STEP);
  assign prdata = (paddr[2] == rca_pkg::REG_TIME_STEP) ? {16'd0, time_step} : 32'd0;
  assign step_eff = (time_step == 16'd0) ? 16'd1 : time_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= 16'd1;
    end else if (cfg_wr) begin
      time_step <= pwdata[15:0];
    end
  end

  // Memory word fields
  assign bin_c1  = ram_rdata[rca_pkg::WORD_W-1 -: SW];
  assign bin_c2  = ram_rdata[CW +: SW];
  assign bin_cnt = ram_rdata[CW-1:0];
  assign cnt_eff = rd_ok ? bin_cnt : '0;

  // Shared multiplier operand select
  always_comb begin
    case (mul_idx)
      2'd0:    begin mul_a = cur.orient_x; mul_b = cur.ref_x; end
      2'd1:    begin mul_a = cur.orient_y; mul_b = cur.ref_y; end
      default: begin mul_a = cur.orient_z; mul_b = cur.ref_z; end
    endcase
    prod = mul_a * mul_b;
  end

  // Saturate the dot product before it is rounded to the working fraction
  always_comb begin
    if (dot > ONE30) begin
      d_sat = ONE30;
    end else if (dot < -ONE30) begin
      d_sat = -ONE30;
    end else begin
      d_sat = dot;
    end
  end

  // P2 from the registered square, widened frame sums for saturation
  always_comb begin
    u       = (U_W'($unsigned(sq)) << 1) + U_W'($unsigned(sq)) + U_W'(HALF_F);
    p2_full = $signed({1'b0, u >> (FRAC_BITS + 1)}) - $signed(HALF_F);
    p2      = X_W'(p2_full);
    s1      = (FW + 1)'(fc1) + (FW + 1)'(x);
    s2      = (FW + 1)'(fc2) + (FW + 1)'(p2);
  end

  // Magnitudes and signed averages for the divider
  always_comb begin
    mag_f1 = fc1[FW-1] ? FW'(-fc1) : FW'(fc1);
    mag_f2 = fc2[FW-1] ? FW'(-fc2) : FW'(fc2);
    mag_b1 = bin_c1[SW-1] ? SW'(-bin_c1) : SW'(bin_c1);
    mag_b2 = bin_c2[SW-1] ? SW'(-bin_c2) : SW'(bin_c2);
    avg1   = fc1[FW-1] ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
    avg2   = fc2[FW-1] ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
    bs1    = (SW + 2)'(bin_c1) + avg1;
    bs2    = (SW + 2)'(bin_c2) + avg2;
    new_c1 = (bs1 > BIN_MAX) ? SW'(BIN_MAX) : (bs1 < BIN_MIN) ? SW'(BIN_MIN) : SW'(bs1);
    new_c2 = (bs2 > BIN_MAX) ? SW'(BIN_MAX) : (bs2 < BIN_MIN) ? SW'(BIN_MIN) : SW'(bs2);
  end

  // Read averages clamped to the result field
  always_comb begin
    if (bin_c1[SW-1]) begin
      rd_c1 = (q1 > NW'(32768)) ? -16'sd32768 : 16'(-$signed({1'b0, q1}));
    end else begin
      rd_c1 = (q1 > NW'(32767)) ? 16'sd32767 : 16'(q1);
    end
    if (bin_c2[SW-1]) begin
      rd_c2 = (q2 > NW'(32768)) ? -16'sd32768 : 16'(-$signed({1'b0, q2}));
    end else begin
      rd_c2 = (q2 > NW'(32767)) ? 16'sd32767 : 16'(q2);
    end
    res_next.lag_time     = 26'(cur.bin_index) * 26'(time_step);
    res_next.sample_count = cnt_eff;
    res_next.c1_average   = (cnt_eff != '0) ? rd_c1 : 16'sd0;
    res_next.c2_average   = (cnt_eff != '0) ? rd_c2 : 16'sd0;
    res_next.has_data     = cnt_eff != '0;
    res_next.dropped      = dropped;
  end

  // Bin addressing and close decisions
  always_comb begin
    sp_ok     = int'(cur.species) < SPECIES_MAX;
    close_ok  = (mol != '0) && sp_ok;
    idx_close = 32'(cur.species) * 32'(LAG_BINS) + 32'(div_quo);
    idx_read  = 32'(item.species) * 32'(LAG_BINS) + 32'(item.bin_index);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rca_pkg::ST_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = rca_pkg::ST_IDLE;
      end
      rca_pkg::ST_IDLE: begin
        if (item_valid) begin
          case (item.action)
            rca_pkg::ACT_ADD:   state_next = rca_pkg::ST_MUL;
            rca_pkg::ACT_CLOSE: state_next = rca_pkg::ST_STEP_GO;
            rca_pkg::ACT_READ:  state_next = rca_pkg::ST_FETCH;
            default:            state_next = rca_pkg::ST_IDLE;
          endcase
        end
      end
      rca_pkg::ST_MUL: begin
        if (mul_idx == 2'd2) state_next = rca_pkg::ST_ROUND;
      end
      rca_pkg::ST_ROUND:  state_next = rca_pkg::ST_SQUARE;
      rca_pkg::ST_SQUARE: state_next = rca_pkg::ST_ACCUM;
      rca_pkg::ST_ACCUM:  state_next = rca_pkg::ST_IDLE;
      rca_pkg::ST_STEP_GO: state_next = rca_pkg::ST_STEP_RUN;
      rca_pkg::ST_STEP_RUN: begin
        if (div_stat.done) begin
          if (close_ok && div_quo < NW'(LAG_BINS)) begin
            state_next = rca_pkg::ST_FETCH;
          end else begin
            state_next = rca_pkg::ST_IDLE;
          end
        end
      end
      rca_pkg::ST_FETCH: state_next = rca_pkg::ST_CHECK;
      rca_pkg::ST_CHECK: begin
        if (cur.action == rca_pkg::ACT_CLOSE) begin
          state_next = (bin_cnt == rca_pkg::COUNT_MAX) ? rca_pkg::ST_IDLE
                                                       : rca_pkg::ST_DIV1_GO;
        end else begin
          state_next = (cnt_eff == '0) ? rca_pkg::ST_OUT : rca_pkg::ST_DIV1_GO;
        end
      end
      rca_pkg::ST_DIV1_GO: state_next = rca_pkg::ST_DIV1_RUN;
      rca_pkg::ST_DIV1_RUN: begin
        if (div_stat.done) state_next = rca_pkg::ST_DIV2_GO;
      end
      rca_pkg::ST_DIV2_GO: state_next = rca_pkg::ST_DIV2_RUN;
      rca_pkg::ST_DIV2_RUN: begin
        if (div_stat.done) begin
          state_next = (cur.action == rca_pkg::ACT_CLOSE) ? rca_pkg::ST_WRITE
                                                          : rca_pkg::ST_OUT;
        end
      end
      rca_pkg::ST_WRITE: state_next = rca_pkg::ST_IDLE;
      rca_pkg::ST_OUT: begin
        if (!(result_valid && result_stall)) state_next = rca_pkg::ST_IDLE;
      end
      default: state_next = rca_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    item_stall  = state != rca_pkg::ST_IDLE;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    ram_we      = 1'b0;
    ram_wdata   = {new_c1, new_c2, CW'(bin_cnt + 1'b1)};
    ram_addr    = addr_reg;
    frame_clear = 1'b0;
    case (state)
      rca_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        ram_addr  = clr_addr;
      end
      rca_pkg::ST_STEP_GO: begin
        div_start = 1'b1;
        div_num   = NW'(cur.elapsed_time);
        div_den   = CW'(step_eff);
      end
      rca_pkg::ST_STEP_RUN: begin
        frame_clear = div_stat.done && !(close_ok && div_quo < NW'(LAG_BINS));
      end
      rca_pkg::ST_CHECK: begin
        frame_clear = (cur.action == rca_pkg::ACT_CLOSE) && (bin_cnt == rca_pkg::COUNT_MAX);
      end
      rca_pkg::ST_DIV1_GO: begin
        div_start = 1'b1;
        if (cur.action == rca_pkg::ACT_CLOSE) begin
          div_num = NW'(mag_f1) + NW'(mol >> 1);
          div_den = mol;
        end else begin
          div_num = NW'(mag_b1) + NW'(cnt_eff >> 1);
          div_den = cnt_eff;
        end
      end
      rca_pkg::ST_DIV2_GO: begin
        div_start = 1'b1;
        if (cur.action == rca_pkg::ACT_CLOSE) begin
          div_num = NW'(mag_f2) + NW'(mol >> 1);
          div_den = mol;
        end else begin
          div_num = NW'(mag_b2) + NW'(cnt_eff >> 1);
          div_den = cnt_eff;
        end
      end
      rca_pkg::ST_WRITE: begin
        ram_we      = 1'b1;
        frame_clear = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rca_pkg::ST_CLEAR;
      clr_addr     <= '0;
      fc1          <= '0;
      fc2          <= '0;
      mol          <= '0;
      dropped      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == rca_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      // Fold one sample into the frame
      if (state == rca_pkg::ST_ACCUM) begin
        fc1 <= (s1[FW] != s1[FW-1]) ? {s1[FW], {(FW - 1){~s1[FW]}}} : FW'(s1);
        fc2 <= (s2[FW] != s2[FW-1]) ? {s2[FW], {(FW - 1){~s2[FW]}}} : FW'(s2);
        if (mol != rca_pkg::COUNT_MAX) mol <= mol + 1'b1;
      end
      if (frame_clear) begin
        fc1 <= '0;
        fc2 <= '0;
        mol <= '0;
      end
      // Frame whose bin lies past the last one
      if (state == rca_pkg::ST_STEP_RUN && div_stat.done && close_ok
          && div_quo >= NW'(LAG_BINS)) begin
        dropped <= 1'b1;
      end
      // Output register: hold under stall, load when free
      if (state == rca_pkg::ST_OUT && !(result_valid && result_stall)) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == rca_pkg::ST_IDLE && item_valid) begin
      cur      <= item;
      dot      <= '0;
      mul_idx  <= '0;
      addr_reg <= ADDR_W'(idx_read);
      rd_ok    <= (int'(item.species) < SPECIES_MAX) && (int'(item.bin_index) < LAG_BINS);
    end
    if (state == rca_pkg::ST_MUL) begin
      dot     <= dot + 34'(prod);
      mul_idx <= mul_idx + 1'b1;
    end
    if (state == rca_pkg::ST_ROUND) begin
      x <= X_W'((d_sat + HALF_D) >>> SH);
    end
    if (state == rca_pkg::ST_SQUARE) begin
      sq <= x * x;
    end
    if (state == rca_pkg::ST_STEP_RUN && div_stat.done) begin
      addr_reg <= ADDR_W'(idx_close);
    end
    if (state == rca_pkg::ST_DIV1_RUN && div_stat.done) q1 <= div_quo;
    if (state == rca_pkg::ST_DIV2_RUN && div_stat.done) q2 <= div_quo;
    if (state == rca_pkg::ST_OUT && !(result_valid && result_stall)) begin
      result <= res_next;
    end
  end

  rca_div #(
    .N_W(NW),
    .D_W(rca_pkg::DIV_D_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .stat (div_stat),
    .quo  (div_quo)
  );

  rca_ram #(
    .WIDTH(rca_pkg::WORD_W),
    .DEPTH(DEPTH)
  ) u_bins (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // An empty frame carries no sums
  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    (mol == '0) |-> (fc1 == '0 && fc2 == '0))
    else $error("frame sums nonzero with no molecules");

  // Bin memory is written only by the clearing pass or a close
  a_ram_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == rca_pkg::ST_CLEAR || state == rca_pkg::ST_WRITE))
    else $error("bin memory written outside clear or close");

  // Divider runs only while the sequencer waits on it
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == rca_pkg::ST_STEP_RUN || state == rca_pkg::ST_DIV1_RUN
                       || state == rca_pkg::ST_DIV2_RUN))
    else $error("divider busy outside a wait state");

  // Dropped flag stays set until reset
  a_dropped_sticky: assert property (@(posedge clk) disable iff (rst)
    (dropped && !rst) |=> dropped)
    else $error("dropped flag cleared without reset");

endmodule

### verif/testbench.sv
// Self-checking testbench for reorientation_correlation_accumulator_core.
// Depends on rca_pkg and the core RTL; holds a bit-accurate predictor of the
// P1/P2 correlation bins in a scoreboard class.
`timescale 1ns / 1ps
module testbench;

  localparam int    NUM_SPECIES = 4;
  localparam int    NUM_BINS    = 1024;
  localparam longint FRAME_LIM  = (64'sd1 <<< 39) - 1;
  localparam longint BIN_LIM    = (64'sd1 <<< 47) - 1;
  localparam longint CNT_MAX    = 64'd16777215;
  localparam int    SETTLE_CYC  = 250;
  localparam int    CYCLE_LIMIT = 1000000;
  localparam int    ITEM_W      = $bits(rca_pkg::rca_item_t);

  // Predicts bin contents and checks returned read transactions
  class corr_scoreboard;
    logic [15:0]   time_step;
    longint        frame_c1, frame_c2, frame_mols;
    longint        bin_c1 [NUM_SPECIES*NUM_BINS];
    longint        bin_c2 [NUM_SPECIES*NUM_BINS];
    longint        bin_cnt[NUM_SPECIES*NUM_BINS];
    bit            dropped;
    rca_pkg::rca_result_t expected_reads[$];
    int            errors;

    function new();
      time_step = 16'd1;
      frame_c1 = 0; frame_c2 = 0; frame_mols = 0;
      dropped = 0; errors = 0;
      foreach (bin_c1[i]) begin
        bin_c1[i] = 0; bin_c2[i] = 0; bin_cnt[i] = 0;
      end
    endfunction

    function longint sat_sum(longint a, longint b, longint lim);
      longint s;
      s = a + b;
      if (s > lim) return lim;
      if (s < -lim - 1) return -lim - 1;
      return s;
    endfunction

    // Divide, rounding half away from zero
    function longint round_div(longint num, longint den);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
    endfunction

    function logic [15:0] clamp16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function void note_item(rca_pkg::rca_item_t it);
      longint d, x, p2, step, h, idx, a1, a2;
      rca_pkg::rca_result_t r;
      case (rca_pkg::rca_action_t'(it.action))
        rca_pkg::ACT_ADD: begin
          d = longint'(it.orient_x) * longint'(it.ref_x)
            + longint'(it.orient_y) * longint'(it.ref_y)
            + longint'(it.orient_z) * longint'(it.ref_z);
          if (d > (64'sd1 <<< 30)) d = 64'sd1 <<< 30;
          if (d < -(64'sd1 <<< 30)) d = -(64'sd1 <<< 30);
          x = (d + 16384) >>> 15;
          p2 = ((3 * x * x + 16384) >>> 16) - 16384;
          frame_c1 = sat_sum(frame_c1, x, FRAME_LIM);
          frame_c2 = sat_sum(frame_c2, p2, FRAME_LIM);
          if (frame_mols < CNT_MAX) frame_mols++;
        end
        rca_pkg::ACT_CLOSE: begin
          step = (time_step == 0) ? 1 : longint'(time_step);
          h = longint'(it.elapsed_time) / step;
          if (frame_mols != 0 && it.species < NUM_SPECIES) begin
            if (h >= NUM_BINS) begin
              dropped = 1;
            end else begin
              idx = it.species * NUM_BINS + h;
              if (bin_cnt[idx] < CNT_MAX) begin
                a1 = round_div(frame_c1, frame_mols);
                a2 = round_div(frame_c2, frame_mols);
                bin_c1[idx] = sat_sum(bin_c1[idx], a1, BIN_LIM);
                bin_c2[idx] = sat_sum(bin_c2[idx], a2, BIN_LIM);
                bin_cnt[idx]++;
              end
            end
          end
          frame_c1 = 0; frame_c2 = 0; frame_mols = 0;
        end
        rca_pkg::ACT_READ: begin
          r = '0;
          a1 = 0; a2 = 0;
          if (it.species < NUM_SPECIES && it.bin_index < NUM_BINS) begin
            idx = it.species * NUM_BINS + it.bin_index;
            r.sample_count = bin_cnt[idx][23:0];
            if (bin_cnt[idx] != 0) begin
              a1 = round_div(bin_c1[idx], bin_cnt[idx]);
              a2 = round_div(bin_c2[idx], bin_cnt[idx]);
            end
          end
          r.lag_time   = 26'(longint'(it.bin_index) * longint'(time_step));
          r.c1_average = clamp16(a1);
          r.c2_average = clamp16(a2);
          r.has_data   = (r.sample_count != 0);
          r.dropped    = dropped;
          expected_reads.push_back(r);
        end
        default: ;
      endcase
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(rca_pkg::rca_result_t got);
      rca_pkg::rca_result_t want;
      if (expected_reads.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      want = expected_reads.pop_front();
      if (got.lag_time != want.lag_time) report("lag_time", got.lag_time, want.lag_time);
      if (got.sample_count != want.sample_count)
        report("sample_count", got.sample_count, want.sample_count);
      if (got.c1_average != want.c1_average)
        report("c1_average", got.c1_average, want.c1_average);
      if (got.c2_average != want.c2_average)
        report("c2_average", got.c2_average, want.c2_average);
      if (got.has_data != want.has_data) report("has_data", got.has_data, want.has_data);
      if (got.dropped != want.dropped) report("dropped", got.dropped, want.dropped);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  rca_pkg::rca_item_t   item;
  logic        result_valid;
  logic        result_stall;
  rca_pkg::rca_result_t result;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  corr_scoreboard sb;
  bit             hold_long;

  reorientation_correlation_accumulator_core i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort on a hung run
  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("reorientation_correlation_accumulator_core regression: fail");
        $finish;
      end
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    int n;
    result_stall <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_long) begin
        n = 400;
        hold_long = 0;
      end else begin
        n = $urandom_range(0, 5);
      end
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      sb.check_result(result);
    end
  end

  task send_item(rca_pkg::rca_item_t it, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
  endtask

  // Wait out every expected read, then a settling time that covers the slowest close
  task drain();
    item_valid <= 1'b0;
    while (sb.expected_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task write_time_step(logic [15:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * rca_pkg::REG_TIME_STEP);
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.time_step = value;
  endtask

  function rca_pkg::rca_item_t blank(rca_pkg::rca_action_t act);
    rca_pkg::rca_item_t it;
    it = '0;
    it.action = act;
    return it;
  endfunction

  // Fill every field with random bits
  function rca_pkg::rca_item_t rand_raw();
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[ITEM_W-1:0];
  endfunction

  function rca_pkg::rca_item_t rand_sample();
    rca_pkg::rca_item_t it;
    int s;
    it = rand_raw();
    it.action = rca_pkg::ACT_ADD;
    // Mostly correlated pairs so the dot product spans the whole range
    if ($urandom_range(0, 9) < 7) begin
      s = $urandom_range(0, 3);
      it.orient_x = (it.ref_x >>> s) + 16'($signed($urandom_range(0, 2047)) - 1024);
      it.orient_y = (it.ref_y >>> s) + 16'($signed($urandom_range(0, 2047)) - 1024);
      it.orient_z = (it.ref_z >>> s) + 16'($signed($urandom_range(0, 2047)) - 1024);
      if ($urandom_range(0, 1)) begin
        it.orient_x = -it.orient_x; it.orient_y = -it.orient_y; it.orient_z = -it.orient_z;
      end
      if ($urandom_range(0, 1)) begin
        it.ref_x = it.ref_x >>> 1; it.ref_y = it.ref_y >>> 1; it.ref_z = it.ref_z >>> 1;
      end
    end
    return it;
  endfunction

  function rca_pkg::rca_item_t rand_close();
    rca_pkg::rca_item_t it;
    longint step;
    it = rand_raw();
    it.action = rca_pkg::ACT_CLOSE;
    step = (sb.time_step == 0) ? 1 : longint'(sb.time_step);
    if ($urandom_range(0, 14) == 0)
      it.elapsed_time = 24'($urandom);
    else
      it.elapsed_time = 24'(longint'($urandom_range(0, 7)) * step
                            + longint'($urandom_range(0, 32'(step - 1))));
    return it;
  endfunction

  function rca_pkg::rca_item_t rand_read();
    rca_pkg::rca_item_t it;
    it = rand_raw();
    it.action = rca_pkg::ACT_READ;
    if ($urandom_range(0, 4) != 0) it.bin_index = 10'($urandom_range(0, 7));
    return it;
  endfunction

  // Frames of samples closed into a bin, reads, and some noise
  task random_phase(int count, bit pause_mid);
    int sent, n;
    rca_pkg::rca_item_t it;
    sent = 0;
    while (sent < count) begin
      if (pause_mid && sent >= count / 2) begin
        drain();
        pause_mid = 0;
      end
      if ($urandom_range(0, 9) == 0) begin
        it = rand_raw();
        send_item(it, 0);
        sent++;
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_item(rand_sample(), 0);
        send_item(rand_close(), 0);
        sent += n + 1;
        n = $urandom_range(0, 2);
        repeat (n) send_item(rand_read(), 0);
        sent += n;
      end
    end
  endtask

  initial begin
    rca_pkg::rca_item_t it;
    logic [15:0] steps[5];
    steps = '{16'd65535, 16'd0, 16'd37, 16'd3, 16'd1};
    sb = new();
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    paddr <= '0; pwdata <= '0;
    hold_long = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    write_time_step(16'd1);

    // Directed: saturating dot products, zero vectors, special closes
    it = blank(rca_pkg::ACT_ADD);
    it.orient_x = -16'sd32768; it.orient_y = -16'sd32768; it.orient_z = -16'sd32768;
    it.ref_x = -16'sd32768; it.ref_y = -16'sd32768; it.ref_z = -16'sd32768;
    send_item(it, 0);
    it.orient_x = 16'sd32767; it.orient_y = 16'sd32767; it.orient_z = 16'sd32767;
    send_item(it, 0);
    send_item(blank(rca_pkg::ACT_ADD), 0);
    it = blank(rca_pkg::ACT_ADD);
    it.orient_x = 16'sd32767; it.ref_x = 16'sd32767;
    send_item(it, 0);
    it = blank(rca_pkg::ACT_CLOSE);
    send_item(it, 0);
    send_item(it, 0);                         // close with an empty frame
    send_item(blank(rca_pkg::ACT_ADD), 0);
    it = blank(rca_pkg::ACT_CLOSE);
    it.elapsed_time = 24'hFFFFFF; it.species = 2'd3;
    send_item(it, 0);                         // lag bin past the end: drop
    it = blank(rca_pkg::ACT_ADD); it.species = 2'd3;
    send_item(it, 0);
    it = blank(rca_pkg::ACT_CLOSE); it.species = 2'd3; it.elapsed_time = 24'd1023;
    send_item(it, 0);                         // last bin of the last species
    it = blank(rca_pkg::ACT_NONE); it.species = 2'd1;
    send_item(it, 0);
    send_item(blank(rca_pkg::ACT_READ), 0);
    it = blank(rca_pkg::ACT_READ); it.species = 2'd3; it.bin_index = 10'd1023;
    send_item(it, 0);
    it = blank(rca_pkg::ACT_READ); it.species = 2'd2; it.bin_index = 10'd5;
    send_item(it, 0);
    random_phase(60, 0);

    // Long receiver hold-off while reads keep coming
    hold_long = 1;
    repeat (16) send_item(rand_read(), 1);
    drain();

    foreach (steps[k]) begin
      write_time_step(steps[k]);
      random_phase(220, k == 1);
      drain();
    end

    if (sb.errors == 0)
      $display("reorientation_correlation_accumulator_core regression: pass");
    else
      $display("reorientation_correlation_accumulator_core regression: fail");
    $finish;
  end
endmodule
